// File: design/cht_pkg.sv
// Package for the chained hash table: field widths, default sizes,
// command codes and the packed node record.
// No dependencies; every other design file imports it.
`default_nettype none

package cht_pkg;

    // Fixed widths of the transaction fields.
    localparam int KEY_W = 32;
    localparam int TAG_W = 16;
    localparam int VAL_W = 32;
    localparam int OP_W  = 2;

    // Default table sizes.
    localparam int DEF_BUCKET_COUNT = 16384;
    localparam int DEF_POOL_NODES   = 2048;

    // Command codes.
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    // Fixed-width part of one pool node.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic [VAL_W-1:0] value;
    } t_node_data;

endpackage

`default_nettype wire

// File: design/cht_bucket.sv
// Bucket index unit: key modulo the bucket count.
// Depends on cht_pkg. A power-of-two count registers the key's low bits; any
// other count registers reciprocal multiply, back multiply, one correction step.
`default_nettype none

module cht_bucket
    import cht_pkg::*;
#(
    parameter int BUCKET_COUNT = DEF_BUCKET_COUNT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [KEY_W-1:0]                i_key,
    output logic                                 o_valid,
    output logic [$clog2(BUCKET_COUNT)-1:0]      o_bucket
);

    localparam int  BKT_W  = $clog2(BUCKET_COUNT);
    localparam bit  IS_POW2 = ((BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0);

    generate
        if (IS_POW2) begin : g_mask
            logic             r_valid;
            logic [BKT_W-1:0] r_bucket;

            // The bucket is simply the low key bits.
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid <= 1'b0;
                end else if (i_start) begin
                    r_valid <= 1'b1;
                end
                if (i_start) begin
                    r_bucket <= i_key[BKT_W-1:0];
                end
            end

            assign o_valid  = r_valid;
            assign o_bucket = r_bucket;
        end else begin : g_recip
            // Floor of two to the key width over the count; the quotient it gives
            // is exact or one short, so one conditional subtract finishes the job.
            localparam logic [KEY_W-1:0] RECIP   =
                KEY_W'((64'd1 << KEY_W) / BUCKET_COUNT);
            localparam logic [KEY_W-1:0] DIVISOR = KEY_W'(BUCKET_COUNT);

            logic               r_v1;
            logic               r_v2;
            logic               r_v3;
            logic               r_valid;
            logic [KEY_W-1:0]   r_key;
            logic [KEY_W-1:0]   r_quot;
            logic [KEY_W-1:0]   r_diff;
            logic [BKT_W-1:0]   r_rem;
            logic [2*KEY_W-1:0] prod;
            logic [KEY_W-1:0]   back;
            logic [KEY_W-1:0]   fixed_rem;

            // Quotient estimate, its multiple of the count, and the correction.
            assign prod      = (2*KEY_W)'(r_key) * (2*KEY_W)'(RECIP);
            assign back      = r_quot * DIVISOR;
            assign fixed_rem = (r_diff >= DIVISOR) ? (r_diff - DIVISOR) : r_diff;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v1    <= 1'b0;
                    r_v2    <= 1'b0;
                    r_v3    <= 1'b0;
                    r_valid <= 1'b0;
                end else begin
                    r_v1 <= i_start;
                    r_v2 <= r_v1;
                    r_v3 <= r_v2;
                    if (i_start) begin
                        r_valid <= 1'b0;
                    end else if (r_v3) begin
                        r_valid <= 1'b1;
                    end
                end
                if (i_start) begin
                    r_key <= i_key;
                end
                if (r_v1) begin
                    r_quot <= prod[2*KEY_W-1:KEY_W];
                end
                if (r_v2) begin
                    r_diff <= r_key - back;
                end
                if (r_v3) begin
                    r_rem <= fixed_rem[BKT_W-1:0];
                end
            end

            assign o_valid  = r_valid;
            assign o_bucket = r_rem;
        end
    endgenerate

endmodule

`default_nettype wire

// File: design/cht_head_ram.sv
// Bucket head memory: one chain head node index per bucket.
// Depends on cht_pkg for default sizes. Single port, registered read.
`default_nettype none

module cht_head_ram
    import cht_pkg::*;
#(
    parameter int BUCKET_COUNT = DEF_BUCKET_COUNT,
    parameter int POOL_NODES   = DEF_POOL_NODES
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_we,
    input  wire logic [$clog2(BUCKET_COUNT)-1:0] i_addr,
    input  wire logic [$clog2(POOL_NODES)-1:0]   i_wdata,
    output logic      [$clog2(POOL_NODES)-1:0]   o_rdata
);

    localparam int NODE_AW = $clog2(POOL_NODES);

    logic [NODE_AW-1:0] mem [BUCKET_COUNT];

    // Write and registered read share the port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        o_rdata <= mem[i_addr];
    end

endmodule

`default_nettype wire

// File: design/cht_node_ram.sv
// Node pool memory: key, tag, value, chain link and owning bucket per node.
// Depends on cht_pkg for the node record. Single port, registered read.
`default_nettype none

module cht_node_ram
    import cht_pkg::*;
#(
    parameter int BUCKET_COUNT = DEF_BUCKET_COUNT,
    parameter int POOL_NODES   = DEF_POOL_NODES
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_we,
    input  wire logic [$clog2(POOL_NODES)-1:0]   i_addr,
    input  wire t_node_data                      i_wdata,
    input  wire logic [$clog2(POOL_NODES)-1:0]   i_wlink,
    input  wire logic [$clog2(BUCKET_COUNT)-1:0] i_wbucket,
    output t_node_data                           o_rdata,
    output logic      [$clog2(POOL_NODES)-1:0]   o_rlink,
    output logic      [$clog2(BUCKET_COUNT)-1:0] o_rbucket
);

    localparam int NODE_AW = $clog2(POOL_NODES);
    localparam int BKT_W   = $clog2(BUCKET_COUNT);

    typedef struct packed {
        t_node_data         data;
        logic [NODE_AW-1:0] link;
        logic [BKT_W-1:0]   bucket;
    } t_node_word;

    t_node_word mem [POOL_NODES];
    t_node_word r_rword;

    // Whole node is written at once on insert; read is registered.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= '{data: i_wdata, link: i_wlink, bucket: i_wbucket};
        end
        r_rword <= mem[i_addr];
    end

    assign o_rdata   = r_rword.data;
    assign o_rlink   = r_rword.link;
    assign o_rbucket = r_rword.bucket;

endmodule

`default_nettype wire

// File: design/chained_hash_table_unit.sv
// Top level of the chained hash table: command sequencer around the bucket
// unit, the bucket head memory and the node pool memory.
// Depends on cht_pkg, cht_bucket, cht_head_ram and cht_node_ram.
//
//   Channel   Handshake                Payload
//   command   start in, busy out        i_op, i_key, i_tag, i_payload
//   result    o_done strobe, 1 cycle    o_found, o_result_value, o_status
//
// An insert runs through the bucket, head, write and done states, with a node
// state added when the head read names an allocated node that must be checked;
// a refused insert goes straight to done. A search runs through bucket, head,
// the node state per node read, then done; clear and unused codes go to done.
// The chain walk is set by the single node memory port, one node read a cycle.
// A bucket count that is not a power of two adds the bucket unit's divide steps.
// Memories get no clearing pass: a head is trusted only if it points below the
// free pointer at a node stamped with the same bucket, so reset and clear are
// immediate. The result strobe cannot be held off; busy stays high until it.
`default_nettype none

module chained_hash_table_unit
    import cht_pkg::*;
#(
    parameter int BUCKET_COUNT = DEF_BUCKET_COUNT,
    parameter int POOL_NODES   = DEF_POOL_NODES
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [OP_W-1:0]  i_op,
    input  wire logic [KEY_W-1:0] i_key,
    input  wire logic [TAG_W-1:0] i_tag,
    input  wire logic [VAL_W-1:0] i_payload,
    output logic                  o_done,
    output logic                  o_found,
    output logic [VAL_W-1:0]      o_result_value,
    output logic                  o_status
);

    localparam int NODE_AW = $clog2(POOL_NODES);
    localparam int BKT_W   = $clog2(BUCKET_COUNT);
    localparam int FP_W    = NODE_AW + 1;
    localparam logic [FP_W-1:0] FP_LIMIT = FP_W'(POOL_NODES);
    localparam logic [FP_W-1:0] FP_FIRST = FP_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BUCKET,
        S_HEAD,
        S_NODE,
        S_WRITE,
        S_DONE
    } t_state;

    t_state             r_state, n_state;
    t_op                r_op, n_op;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [TAG_W-1:0]   r_tag, n_tag;
    logic [VAL_W-1:0]   r_payload, n_payload;
    logic [FP_W-1:0]    r_fp, n_fp;
    logic [NODE_AW-1:0] r_ptr, n_ptr;
    logic [NODE_AW-1:0] r_link, n_link;
    logic               r_found, n_found;
    logic [VAL_W-1:0]   r_value, n_value;
    logic               r_status, n_status;

    logic               bkt_start;
    logic               bkt_valid;
    logic [BKT_W-1:0]   bkt_idx;

    logic               head_we;
    logic [NODE_AW-1:0] head_rdata;

    logic               node_we;
    logic [NODE_AW-1:0] node_addr;
    t_node_data         node_wdata;
    t_node_data         node_rdata;
    logic [NODE_AW-1:0] node_rlink;
    logic [BKT_W-1:0]   node_rbucket;

    logic               head_live;
    logic               node_hit;

    // Bucket index of the accepted key; held until the next insert or search.
    cht_bucket #(
        .BUCKET_COUNT(BUCKET_COUNT)
    ) u_bucket (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (bkt_start),
        .i_key   (i_key),
        .o_valid (bkt_valid),
        .o_bucket(bkt_idx)
    );

    cht_head_ram #(
        .BUCKET_COUNT(BUCKET_COUNT),
        .POOL_NODES  (POOL_NODES)
    ) u_head_ram (
        .i_clk  (i_clk),
        .i_we   (head_we),
        .i_addr (bkt_idx),
        .i_wdata(r_fp[NODE_AW-1:0]),
        .o_rdata(head_rdata)
    );

    cht_node_ram #(
        .BUCKET_COUNT(BUCKET_COUNT),
        .POOL_NODES  (POOL_NODES)
    ) u_node_ram (
        .i_clk    (i_clk),
        .i_we     (node_we),
        .i_addr   (node_addr),
        .i_wdata  (node_wdata),
        .i_wlink  (r_link),
        .i_wbucket(bkt_idx),
        .o_rdata  (node_rdata),
        .o_rlink  (node_rlink),
        .o_rbucket(node_rbucket)
    );

    // A head counts only if it names a node allocated since the last clear.
    assign head_live  = (head_rdata != '0) && ({1'b0, head_rdata} < r_fp);
    assign node_hit   = (node_rdata.key == r_key) && (node_rdata.tag == r_tag);
    assign node_wdata = '{key: r_key, tag: r_tag, value: r_payload};

    // Command sequencer: next state, memory controls and result values.
    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_key     = r_key;
        n_tag     = r_tag;
        n_payload = r_payload;
        n_fp      = r_fp;
        n_ptr     = r_ptr;
        n_link    = r_link;
        n_found   = r_found;
        n_value   = r_value;
        n_status  = r_status;
        bkt_start = 1'b0;
        head_we   = 1'b0;
        node_we   = 1'b0;
        node_addr = r_fp[NODE_AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op      = t_op'(i_op);
                    n_key     = i_key;
                    n_tag     = i_tag;
                    n_payload = i_payload;
                    n_found   = 1'b0;
                    n_value   = '0;
                    n_status  = 1'b0;
                    case (i_op)
                        OP_INSERT: begin
                            if (r_fp >= FP_LIMIT) begin
                                n_status = 1'b1;
                                n_state  = S_DONE;
                            end else begin
                                bkt_start = 1'b1;
                                n_state   = S_BUCKET;
                            end
                        end
                        OP_SEARCH: begin
                            bkt_start = 1'b1;
                            n_state   = S_BUCKET;
                        end
                        OP_CLEAR: begin
                            n_fp    = FP_FIRST;
                            n_state = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_BUCKET: begin
                // The head read is issued on the edge that leaves this state.
                if (bkt_valid) begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                if (head_live) begin
                    node_addr = head_rdata;
                    n_ptr     = head_rdata;
                    n_state   = S_NODE;
                end else if (r_op == OP_INSERT) begin
                    n_link  = '0;
                    n_state = S_WRITE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_NODE: begin
                if (r_op == OP_INSERT) begin
                    // A stale head points at a node of another bucket.
                    n_link  = (node_rbucket == bkt_idx) ? r_ptr : '0;
                    n_state = S_WRITE;
                end else if (node_rbucket != bkt_idx) begin
                    n_state = S_DONE;
                end else if (node_hit) begin
                    n_found = 1'b1;
                    n_value = node_rdata.value;
                    n_state = S_DONE;
                end else if (node_rlink == '0) begin
                    n_state = S_DONE;
                end else begin
                    node_addr = node_rlink;
                end
            end
            S_WRITE: begin
                node_we = 1'b1;
                head_we = 1'b1;
                n_fp    = r_fp + 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, transaction registers and registered results.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fp     <= FP_FIRST;
            r_found  <= 1'b0;
            r_value  <= '0;
            r_status <= 1'b0;
            r_op     <= OP_INSERT;
        end else begin
            r_state  <= n_state;
            r_fp     <= n_fp;
            r_found  <= n_found;
            r_value  <= n_value;
            r_status <= n_status;
            r_op     <= n_op;
        end
        r_key     <= n_key;
        r_tag     <= n_tag;
        r_payload <= n_payload;
        r_ptr     <= n_ptr;
        r_link    <= n_link;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = (r_state == S_DONE);
    assign o_found        = r_found;
    assign o_result_value = r_value;
    assign o_status       = r_status;

    // The result strobe lasts exactly one cycle.
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // A hit is only reported for a search.
    a_found_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_found) |-> (r_op == OP_SEARCH))
        else $error("hit reported for a command other than search");

    // A refusal is only reported for an insert.
    a_status_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status) |-> (r_op == OP_INSERT))
        else $error("pool full reported for a command other than insert");

    // The free pointer never names node zero and never passes the pool end.
    a_fp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fp != '0) && (r_fp <= FP_LIMIT))
        else $error("free pointer out of range");

    // Node and head memories are written together, only below the pool end.
    a_write_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        node_we |-> (head_we && (r_fp < FP_LIMIT)))
        else $error("node write without head write or past pool end");

endmodule

`default_nettype wire

// File: tb/tb_chained_hash_table_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for chained_hash_table_unit: directed and random
// command streams checked against a mirror of the table.
// Depends on cht_pkg and the chained_hash_table_unit RTL.

import cht_pkg::*;

// One result transaction as the block presents it.
typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] value;
    logic             status;
} t_lookup_answer;

// Mirror of the table contents; queues the answer each accepted command should
// produce and compares the block's results against them in order.
class table_mirror;
    bit [10:0]      chain_head [DEF_BUCKET_COUNT];
    bit [KEY_W-1:0] node_key   [DEF_POOL_NODES];
    bit [TAG_W-1:0] node_tag   [DEF_POOL_NODES];
    bit [VAL_W-1:0] node_value [DEF_POOL_NODES];
    bit [10:0]      node_link  [DEF_POOL_NODES];
    bit [11:0]      next_free;
    t_lookup_answer pending_answers [$];
    int             mismatch_count;

    function new();
        mismatch_count = 0;
        empty_buckets();
    endfunction

    function void empty_buckets();
        foreach (chain_head[i]) chain_head[i] = '0;
        next_free = 12'd1;
    endfunction

    // Apply one accepted command to the mirror and queue its answer.
    function void note_command(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                               logic [TAG_W-1:0] tag, logic [VAL_W-1:0] payload);
        t_lookup_answer answer;
        int             bucket;
        int             node;
        int             steps;
        answer = '0;
        bucket = int'(key % DEF_BUCKET_COUNT);
        case (op)
            OP_INSERT: begin
                if (next_free >= DEF_POOL_NODES || next_free == 0) begin
                    answer.status = 1'b1;
                end else begin
                    node = next_free;
                    node_key[node]     = key;
                    node_tag[node]     = tag;
                    node_value[node]   = payload;
                    node_link[node]    = chain_head[bucket];
                    chain_head[bucket] = node[10:0];
                    next_free          = next_free + 12'd1;
                end
            end
            OP_SEARCH: begin
                // Newest entry sits at the head, so the first match wins.
                node  = chain_head[bucket];
                steps = 0;
                while (node != 0 && node < DEF_POOL_NODES && steps < DEF_POOL_NODES) begin
                    if (node_key[node] == key && node_tag[node] == tag) begin
                        answer.found = 1'b1;
                        answer.value = node_value[node];
                        break;
                    end
                    node = node_link[node];
                    steps++;
                end
            end
            OP_CLEAR: empty_buckets();
            default: ;
        endcase
        pending_answers.push_back(answer);
    endfunction

    task report_mismatch(string what);
        $display("%0t ns: mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Compare one result transaction with the oldest queued answer.
    task check_answer(logic found, logic [VAL_W-1:0] value, logic status);
        t_lookup_answer want;
        if (pending_answers.size() == 0) begin
            report_mismatch("result strobe with no command outstanding");
        end else begin
            want = pending_answers.pop_front();
            if (found !== want.found)
                report_mismatch($sformatf("found %b, expected %b", found, want.found));
            if (value !== want.value)
                report_mismatch($sformatf("result_value %h, expected %h", value, want.value));
            if (status !== want.status)
                report_mismatch($sformatf("status %b, expected %b", status, want.status));
        end
    endtask
endclass

module tb_chained_hash_table_unit;

    localparam int               CLK_PERIOD   = 10;
    localparam int               RESET_CYCLES = 6;
    localparam int               RANDOM_ITEMS = 1050;
    localparam int               DRAIN_CYCLES = 64;
    // A search walks at most every node inserted since the last clear, about a
    // thousand here, so even worst-case chains for every command stay far below.
    localparam int               CYCLE_LIMIT  = 5000000;
    localparam logic [OP_W-1:0]  OP_UNUSED    = 2'd3;

    typedef struct {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_stored_entry;

    logic             i_clk     = 1'b0;
    logic             i_rst_n   = 1'b0;
    logic             start     = 1'b0;
    logic [OP_W-1:0]  i_op      = '0;
    logic [KEY_W-1:0] i_key     = '0;
    logic [TAG_W-1:0] i_tag     = '0;
    logic [VAL_W-1:0] i_payload = '0;
    logic             busy;
    logic             o_done;
    logic             o_found;
    logic [VAL_W-1:0] o_result_value;
    logic             o_status;

    table_mirror      mirror = new();
    t_stored_entry    live_entries [$];
    logic [17:0]      hot_upper [4];
    logic [13:0]      hot_bucket [10];
    logic [TAG_W-1:0] hot_tag [4];
    int               sender_idle_pct = 0;
    int               cycle_count = 0;

    chained_hash_table_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_key          (i_key),
        .i_tag          (i_tag),
        .i_payload      (i_payload),
        .o_done         (o_done),
        .o_found        (o_found),
        .o_result_value (o_result_value),
        .o_status       (o_status)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Results are checked before a command accepted at the same edge is noted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done)
                mirror.check_answer(o_found, o_result_value, o_status);
            if (start && !busy)
                mirror.note_command(i_op, i_key, i_tag, i_payload);
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("chained_hash_table_unit regression: fail");
            $finish;
        end
    end

    // Present one command at the falling edge and hold it until accepted.
    task automatic send_command(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                logic [TAG_W-1:0] tag, logic [VAL_W-1:0] payload);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start     <= 1'b1;
        i_op      <= op;
        i_key     <= key;
        i_tag     <= tag;
        i_payload <= payload;
        do @(posedge i_clk); while (busy);
    endtask

    // Keys mostly land in a few hot buckets with a few repeated upper parts,
    // so chains grow and duplicate keys occur.
    function automatic logic [KEY_W-1:0] make_key();
        logic [17:0] upper;
        logic [13:0] bucket;
        upper  = ($urandom_range(1) == 0) ? hot_upper[$urandom_range(3)] : 18'($urandom());
        bucket = ($urandom_range(3) == 0) ? 14'($urandom()) : hot_bucket[$urandom_range(9)];
        return {upper, bucket};
    endfunction

    function automatic logic [TAG_W-1:0] make_tag();
        return ($urandom_range(1) == 0) ? hot_tag[$urandom_range(3)] : 16'($urandom());
    endfunction

    // One random transaction: inserts and searches dominate, with the odd
    // clear and unused code mixed in.
    task automatic random_command();
        int               pick;
        int               variant;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        t_stored_entry    entry;
        pick = $urandom_range(99);
        if (pick < 42) begin
            key = make_key();
            tag = make_tag();
            send_command(OP_INSERT, key, tag, $urandom());
            entry.key = key;
            entry.tag = tag;
            live_entries.push_back(entry);
        end else if (pick < 94) begin
            variant = $urandom_range(9);
            if (live_entries.size() == 0 || variant >= 8) begin
                key = make_key();
                tag = make_tag();
            end else begin
                entry = live_entries[$urandom_range(live_entries.size() - 1)];
                key   = entry.key;
                tag   = entry.tag;
                // Near misses: same key with another tag, or same bucket.
                if (variant == 6)
                    tag = tag ^ 16'($urandom_range(1, 65535));
                else if (variant == 7)
                    key = key ^ (32'($urandom_range(1, 262143)) << 14);
            end
            send_command(OP_SEARCH, key, tag, $urandom());
        end else if (pick < 97) begin
            send_command(OP_CLEAR, $urandom(), 16'($urandom()), $urandom());
            live_entries.delete();
        end else begin
            send_command(OP_UNUSED, $urandom(), 16'($urandom()), $urandom());
        end
    endtask

    initial begin
        hot_upper[0] = '0;
        hot_upper[1] = '1;
        hot_upper[2] = 18'($urandom());
        hot_upper[3] = 18'($urandom());
        hot_bucket[0] = '0;
        hot_bucket[1] = '1;
        for (int i = 2; i < 10; i++) hot_bucket[i] = 14'($urandom());
        hot_tag[0] = '0;
        hot_tag[1] = '1;
        hot_tag[2] = 16'($urandom());
        hot_tag[3] = 16'($urandom());

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, field extremes, chaining order, tag and key
        // mismatches inside one bucket, the unused code and a clear.
        send_command(OP_SEARCH, '0, '0, '1);
        send_command(OP_INSERT, '0, '0, '0);
        send_command(OP_INSERT, '1, '1, '1);
        send_command(OP_SEARCH, '0, '0, '1);
        send_command(OP_SEARCH, '1, '1, '0);
        // Key 0x4000 shares a bucket with key 0.
        send_command(OP_INSERT, 32'h0000_4000, '0, 32'ha5a5_a5a5);
        send_command(OP_SEARCH, 32'h0000_4000, '0, '0);
        send_command(OP_SEARCH, '0, '0, '0);
        // A newer duplicate of key 0 hides the older one.
        send_command(OP_INSERT, '0, '0, 32'h1234_5678);
        send_command(OP_SEARCH, '0, '0, '0);
        send_command(OP_SEARCH, '0, 16'h0001, '0);
        send_command(OP_SEARCH, 32'h0000_8000, '0, '0);
        send_command(OP_SEARCH, 32'hffff_bfff, '1, '0);
        send_command(OP_UNUSED, '1, '1, '1);
        send_command(OP_SEARCH, '1, '1, '0);
        send_command(OP_UNUSED, '0, '0, '0);
        send_command(OP_CLEAR, '1, '1, '1);
        send_command(OP_SEARCH, '0, '0, '0);
        send_command(OP_SEARCH, '1, '1, '0);
        send_command(OP_INSERT, 32'h8000_3fff, 16'h8000, 32'h8000_0001);
        send_command(OP_SEARCH, 32'h8000_3fff, 16'h8000, '0);
        send_command(OP_CLEAR, '0, '0, '0);

        // Random phases: back to back, heavy sender gaps, lighter gaps, back to back again.
        sender_idle_pct = 0;
        repeat (RANDOM_ITEMS / 4) random_command();
        sender_idle_pct = 46;
        repeat (RANDOM_ITEMS / 4) random_command();
        sender_idle_pct = 29;
        repeat (RANDOM_ITEMS / 4) random_command();
        sender_idle_pct = 0;
        repeat (RANDOM_ITEMS / 4) random_command();

        @(negedge i_clk);
        start <= 1'b0;

        // Drain outstanding results, then watch for stray strobes.
        while (mirror.pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mirror.mismatch_count == 0) begin
            $display("chained_hash_table_unit regression: pass");
        end else begin
            $display("chained_hash_table_unit regression: fail");
        end
        $finish;
    end

endmodule
